// ===== rtl/rrbts_pkg.sv =====
// shared types, codes and widths of the round-robin blocking task scheduler
package rrbts_pkg;

  localparam int DEF_TASK_SLOTS = 16;

  // payload widths
  localparam int OP_W     = 3;
  localparam int MS_W     = 16;
  localparam int HANDLE_W = 4;
  localparam int TIME_W   = 31;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;

  // number of task slots a handle can name
  localparam int HANDLE_SLOTS = 1 << HANDLE_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_SLEEP  = 3'd1;
  localparam logic [OP_W-1:0] OP_WAIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_EXIT   = 3'd4;
  localparam logic [OP_W-1:0] OP_POLL   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] RES_SWITCHED = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] RES_CREATED  = 2'd2;
  localparam logic [STATUS_W-1:0] RES_FULL     = 2'd3;

  // per-task state
  typedef enum logic [2:0] {
    TS_SLEEP  = 3'd0,
    TS_WAIT   = 3'd1,
    TS_READ   = 3'd2,
    TS_RUN    = 3'd3,
    TS_READY  = 3'd4,
    TS_DONE   = 3'd5,
    TS_UNUSED = 3'd6
  } task_st_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } rrbts_state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic create;
    logic block;
    logic scan_start;
    logic issue;
    logic commit;
    logic res_none;
    logic out_load;
  } rrbts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic op_create;
    logic op_block;
    logic running;
    logic issue_done;
    logic pick;
    logic last_eval;
    logic out_free;
  } rrbts_sts_t;

endpackage

// ===== rtl/rrbts_if.sv =====
// request and response channel interfaces of the task scheduler
interface rrbts_req_if import rrbts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [MS_W-1:0]     sleep_ms;
  logic [HANDLE_W-1:0] wait_handle;
  logic [TIME_W-1:0]   now_ms;
  logic                char_valid;
  logic [CHAR_W-1:0]   char_code;

  modport source (
    output valid, operation, sleep_ms, wait_handle, now_ms, char_valid, char_code,
    input  ready
  );
  modport sink (
    input  valid, operation, sleep_ms, wait_handle, now_ms, char_valid, char_code,
    output ready
  );
endinterface

interface rrbts_rsp_if import rrbts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] next_task;
  logic [HANDLE_W-1:0] new_handle;
  logic [CHAR_W-1:0]   char_out;
  logic                char_taken;

  modport source (
    output valid, status, next_task, new_handle, char_out, char_taken,
    input  ready
  );
  modport sink (
    input  valid, status, next_task, new_handle, char_out, char_taken,
    output ready
  );
endinterface

// ===== rtl/round_robin_blocking_task_scheduler_core.sv =====
// top level of the round-robin blocking task scheduler
//
// req carries one scheduler operation per beat (create, sleep, wait for task,
// read char, exit, poll) with the current millisecond time and an optional
// offered character. rsp returns exactly one beat per request: status, the
// task now current, the handle of a created task and any character handed to
// a woken reader.
// one request is in work at a time. create, and poll while a task runs,
// go from decode straight to the finish step. a scheduling pass reads the
// task state table one slot per cycle through its single read port and
// stops at the first slot that may run, or after every created task has been
// examined; the next request beat can be taken in the cycle after the result
// is loaded.
// the response sits in an output register, so a new request is accepted while
// an earlier response still waits on a stalled rsp; that request's result
// then waits in the finish state until the register is taken.
// reset: task 0 running and current, one task created, all other slots unused,
// no response pending. no clearing pass is needed.
module round_robin_blocking_task_scheduler_core import rrbts_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  rrbts_req_if.sink   req,
  rrbts_rsp_if.source rsp
);

  // command and status between sequencer and table datapath
  rrbts_cmd_t cmd;
  rrbts_sts_t sts;

  // sequencer: decode, scan and finish steps
  rrbts_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // task table, scan pipeline and response register
  rrbts_dpath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

// ===== rtl/rrbts_ctrl.sv =====
// sequencing state machine of the task scheduler
module rrbts_ctrl import rrbts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rrbts_sts_t sts,
  output rrbts_cmd_t cmd
);

  rrbts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.op_create) begin
          cmd.create = 1'b1;
          state_next = S_FINISH;
        end else if (sts.op_block && sts.running) begin
          cmd.block      = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (sts.running) begin
          // poll with a running task: nothing to schedule
          state_next = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = !sts.issue_done;
        priority if (sts.pick) begin
          cmd.commit = 1'b1;
          state_next = S_FINISH;
        end else if (sts.last_eval) begin
          cmd.res_none = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rrbts_dpath.sv =====
// task table, scan pipeline and result register of the task scheduler
module rrbts_dpath import rrbts_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  rrbts_req_if.sink  req,
  rrbts_rsp_if.source rsp,
  input  rrbts_cmd_t cmd,
  output rrbts_sts_t sts
);

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);

  // latched request
  logic [OP_W-1:0]     op_q;
  logic [MS_W-1:0]     ms_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TIME_W-1:0]   now_q;
  logic                cv_q;
  logic [CHAR_W-1:0]   code_q;

  // scheduler state
  logic [IW-1:0]         cur;
  logic [CW-1:0]         count;
  logic                  running;
  logic [TASK_SLOTS-1:0] done_flags;
  logic [TASK_SLOTS-1:0] st_valid;

  // task table memories
  task_st_t            st_mem    [TASK_SLOTS];
  logic [TIME_W-1:0]   wake_mem  [TASK_SLOTS];
  logic [HANDLE_W-1:0] await_mem [TASK_SLOTS];

  // scan pipeline
  logic [IW-1:0]       scan_idx;
  logic [CW-1:0]       issue_cnt;
  logic [CW-1:0]       eval_cnt;
  logic                rd_valid;
  logic [IW-1:0]       rd_idx;
  task_st_t            rd_st;
  logic                rd_stv;
  logic [TIME_W-1:0]   rd_wake;
  logic [HANDLE_W-1:0] rd_await;

  // result
  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_new;
  logic [CHAR_W-1:0]   res_char;
  logic                res_taken;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_next;
  logic [HANDLE_W-1:0] out_new;
  logic [CHAR_W-1:0]   out_char;
  logic                out_taken;

  logic                full;
  logic                st_we;
  logic [IW-1:0]       st_waddr;
  task_st_t            st_wdata;
  task_st_t            eff_st;
  logic                done_hit;
  logic [TIME_W-1:0]   elapsed;
  logic                pick_ok;
  logic                in_fire;

  // round-robin successor within the created tasks
  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    logic [CW-1:0] n;
    n = CW'(i) + CW'(1);
    return (n == count) ? '0 : n[IW-1:0];
  endfunction

  assign full    = (count == CW'(TASK_SLOTS));
  assign in_fire = req.valid && req.ready;

  // single write port of the state table
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cur;
    st_wdata = TS_RUN;
    priority if (cmd.create && !full) begin
      st_we    = 1'b1;
      st_waddr = count[IW-1:0];
      st_wdata = TS_READY;
    end else if (cmd.block) begin
      st_we = 1'b1;
      priority case (op_q)
        OP_SLEEP: st_wdata = TS_SLEEP;
        OP_WAIT:  st_wdata = TS_WAIT;
        OP_READ:  st_wdata = TS_READ;
        default:  st_wdata = TS_DONE;
      endcase
    end else if (cmd.commit) begin
      st_we    = 1'b1;
      st_waddr = rd_idx;
      st_wdata = TS_RUN;
    end else begin
      st_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (cmd.block && op_q == OP_SLEEP) begin
      wake_mem[cur] <= now_q + TIME_W'(ms_q);
    end
    if (cmd.block && op_q == OP_WAIT) begin
      await_mem[cur] <= handle_q;
    end
    if (cmd.issue) begin
      rd_st    <= st_mem[scan_idx];
      rd_wake  <= wake_mem[scan_idx];
      rd_await <= await_mem[scan_idx];
      rd_stv   <= st_valid[scan_idx];
      rd_idx   <= scan_idx;
    end
  end

  // slots never written hold their reset state
  always_comb begin
    if (rd_stv) begin
      eff_st = rd_st;
    end else if (rd_idx == '0) begin
      eff_st = TS_RUN;
    end else begin
      eff_st = TS_UNUSED;
    end
  end

  // awaited task finished; handles beyond the table never finish
  always_comb begin
    done_hit = 1'b0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (j < HANDLE_SLOTS && rd_await == HANDLE_W'(j) && done_flags[j]) begin
        done_hit = 1'b1;
      end
    end
  end

  // wake time passed within half the timer range
  assign elapsed = now_q - rd_wake;

  always_comb begin
    unique case (eff_st)
      TS_READY: pick_ok = 1'b1;
      TS_WAIT:  pick_ok = done_hit;
      TS_SLEEP: pick_ok = !elapsed[TIME_W-1];
      TS_READ:  pick_ok = cv_q;
      default:  pick_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      count      <= CW'(1);
      running    <= 1'b1;
      done_flags <= '0;
      st_valid   <= '0;
      rd_valid   <= 1'b0;
      scan_idx   <= '0;
      issue_cnt  <= '0;
      eval_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.create && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.block) begin
        running <= 1'b0;
        if (op_q == OP_EXIT) begin
          done_flags[cur] <= 1'b1;
        end
      end
      if (st_we) begin
        st_valid[st_waddr] <= 1'b1;
      end
      if (cmd.commit) begin
        cur     <= rd_idx;
        running <= 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx  <= next_slot(cur);
        issue_cnt <= '0;
        eval_cnt  <= '0;
        rd_valid  <= 1'b0;
      end else begin
        if (cmd.issue) begin
          scan_idx  <= next_slot(scan_idx);
          issue_cnt <= issue_cnt + CW'(1);
        end
        if (rd_valid) begin
          eval_cnt <= eval_cnt + CW'(1);
        end
        rd_valid <= cmd.issue && !cmd.commit;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request latch and result fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q     <= req.operation;
      ms_q     <= req.sleep_ms;
      handle_q <= req.wait_handle;
      now_q    <= req.now_ms;
      cv_q     <= req.char_valid;
      code_q   <= req.char_code;
    end
    if (in_fire) begin
      res_status <= RES_SWITCHED;
      res_new    <= '0;
      res_char   <= '0;
      res_taken  <= 1'b0;
    end
    if (cmd.create) begin
      if (full) begin
        res_status <= RES_FULL;
      end else begin
        res_status <= RES_CREATED;
        res_new    <= HANDLE_W'(count);
      end
    end
    if (cmd.res_none) begin
      res_status <= RES_NONE;
    end
    if (cmd.commit && eff_st == TS_READ) begin
      res_char  <= code_q;
      res_taken <= 1'b1;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_next   <= HANDLE_W'(cur);
      out_new    <= res_new;
      out_char   <= res_char;
      out_taken  <= res_taken;
    end
  end

  assign req.ready      = cmd.in_ready;
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.next_task  = out_next;
  assign rsp.new_handle = out_new;
  assign rsp.char_out   = out_char;
  assign rsp.char_taken = out_taken;

  assign sts.in_valid   = req.valid;
  assign sts.op_create  = (op_q == OP_CREATE);
  assign sts.op_block   = (op_q == OP_SLEEP) || (op_q == OP_WAIT) ||
                          (op_q == OP_READ) || (op_q == OP_EXIT);
  assign sts.running    = running;
  assign sts.issue_done = (issue_cnt == count);
  assign sts.pick       = rd_valid && pick_ok;
  assign sts.last_eval  = rd_valid && ((eval_cnt + CW'(1)) == count);
  assign sts.out_free   = !out_valid || rsp.ready;

endmodule

// ===== rtl/rrbts_checker.sv =====
// port-level checks of the task scheduler, bound to the top level
module rrbts_checker import rrbts_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [HANDLE_W-1:0] rsp_new_handle,
  input logic [CHAR_W-1:0]   rsp_char_out,
  input logic                rsp_char_taken
);

  // a response beat is held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  // one request in work: no request beat right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  // a handle is reported only for a created task
  a_handle_only_on_create: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != RES_CREATED |-> rsp_new_handle == '0)
    else $error("new handle without a created task");

  // a character is only handed over on a switch to a reader
  a_char_on_switch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_char_taken |-> rsp_status == RES_SWITCHED)
    else $error("character taken without a switch");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_char_taken |-> rsp_char_out == '0)
    else $error("character out without a taken character");

endmodule

bind round_robin_blocking_task_scheduler_core rrbts_checker u_rrbts_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_new_handle (rsp.new_handle),
  .rsp_char_out   (rsp.char_out),
  .rsp_char_taken (rsp.char_taken)
);
